FILE: hw/rtl/dmi_pkg.sv
`timescale 1ns / 1ps
package dmi_pkg;

  localparam int PRICE_BITS_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int IN_PRICE_BITS = 32;
  localparam int PERIOD_BITS   = 8;
  localparam int PERIOD_RESET  = 14;
  localparam int PCT_OUT_BITS  = 23;
  localparam int PCT_INT_BITS  = 7;
  localparam int PCT_SCALE     = 100;
  localparam int ACC_BITS      = 56;
  localparam int DXSUM_BITS    = 31;
  localparam int DIV_BITS      = 64;
  localparam int DIV_CNT_BITS  = 7;

  localparam logic OP_BAR   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Operand set for the shared divider
  typedef enum logic [2:0] {
    DIV_TR,
    DIV_PM,
    DIV_MM,
    DIV_PDI,
    DIV_MDI,
    DIV_DX,
    DIV_AVG
  } div_sel_t;

  typedef enum logic [1:0] {
    OVR_NONE,
    OVR_ZERO,
    OVR_FULL
  } ovr_t;

  typedef struct packed {
    logic     capture;
    logic     clear;
    logic     prep;
    logic     div_start;
    div_sel_t div_sel;
    logic     adx_prep;
    logic     deliver;
    logic     blank;
  } dmi_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic seed_open;
    logic dir_ready;
    logic adx_need_div;
    logic div_done;
    logic div_busy;
    logic out_free;
  } dmi_stat_t;

endpackage

FILE: hw/rtl/dmi_if.sv
`timescale 1ns / 1ps
interface dmi_bar_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] bar_high;
  logic [31:0] bar_low;
  logic [31:0] bar_close;

  modport source (output valid, opcode, bar_high, bar_low, bar_close, input ready);
  modport sink (input valid, opcode, bar_high, bar_low, bar_close, output ready);
endinterface

interface dmi_result_if;
  logic        valid;
  logic        ready;
  logic [22:0] plus_di;
  logic [22:0] neg_di;
  logic [22:0] dx_value;
  logic [22:0] adx_value;
  logic        di_valid;
  logic        adx_valid;

  modport source (output valid, plus_di, neg_di, dx_value, adx_value, di_valid, adx_valid,
                  input ready);
  modport sink (input valid, plus_di, neg_di, dx_value, adx_value, di_valid, adx_valid,
                output ready);
endinterface

interface dmi_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] period;

  modport source (output valid, period, input ready);
  modport sink (input valid, period, output ready);
endinterface

FILE: hw/rtl/directional_movement_index.sv
`timescale 1ns / 1ps
// A clear request or a bar inside the seed window passes from capture through the prep
// state straight to delivery; a full bar also runs its divides on the shared divider.
// Throughput: one bar at a time; the next request is taken once the result is registered.
// Bar processing time is set by the one shared restoring divider, one quotient bit per cycle.
// Reset (rst, synchronous): clears all indicator state and sets period to 14.
module directional_movement_index import dmi_pkg::*; #(
  parameter int PRICE_BITS    = PRICE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  dmi_bar_if.sink      bar,
  dmi_result_if.source result,
  dmi_cfg_if.sink      cfg
);

  // Period register. Writes must come only while the block is idle; the block itself
  // does not enforce this, cfg.ready is tied high; a new period applies from the next bar on.
  logic [PERIOD_BITS-1:0] period;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_BITS'(PERIOD_RESET);
    end else if (cfg.valid) begin
      period <= cfg.period;
    end
  end

  dmi_cmd_t  cmd;
  dmi_stat_t stat;

  // Controller: walks each bar through front end; full bars get three smoothing divides
  // (only after the seed window), +DI, -DI, DX and the ADX update.
  dmi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .bar_valid (bar.valid),
    .bar_ready (bar.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: holds the indicator state, the shared divider and the
  // output register that decouples the result from the next request.
  dmi_datapath #(
    .PRICE_BITS    (PRICE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_opcode     (bar.opcode),
    .in_high       (bar.bar_high),
    .in_low        (bar.bar_low),
    .in_close      (bar.bar_close),
    .period        (period),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_plus_di   (result.plus_di),
    .out_neg_di    (result.neg_di),
    .out_dx        (result.dx_value),
    .out_adx       (result.adx_value),
    .out_di_valid  (result.di_valid),
    .out_adx_valid (result.adx_valid)
  );

  // ADX is never valid ahead of the directional indicators.
  a_adx_after_di: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (!result.adx_valid || result.di_valid))
    else $error("adx_valid without di_valid");

  // A result without valid DI carries zero indicators.
  a_blank_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.di_valid) |->
      (result.plus_di == '0 && result.neg_di == '0 && result.dx_value == '0 &&
       result.adx_value == '0))
    else $error("nonzero fields in a blank result");

  // A new request is never accepted while the divider is working.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (bar.valid && bar.ready) |-> !stat.div_busy)
    else $error("request accepted while divider busy");

  // The divider only finishes after it was busy.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> $past(stat.div_busy))
    else $error("divider done without a run");

endmodule

FILE: hw/rtl/dmi_divider.sv
`timescale 1ns / 1ps
module dmi_divider import dmi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [ACC_BITS-1:0]     rem_init,
  input  logic [DIV_BITS-1:0]     bits_init,
  input  logic [ACC_BITS-1:0]     divisor,
  input  logic [DIV_CNT_BITS-1:0] count,
  output logic                    busy,
  output logic                    done,
  output logic [DIV_BITS-1:0]     quotient
);

  logic [ACC_BITS-1:0]     rem;
  logic [DIV_BITS-1:0]     bits;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [ACC_BITS:0]       rem_sh;
  logic [ACC_BITS:0]       rem_diff;
  logic                    q_bit;

  // one restoring step per cycle
  always_comb begin
    rem_sh   = {rem, bits[DIV_BITS-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    q_bit    = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= count;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= rem_init;
      bits     <= bits_init;
      quotient <= '0;
    end else if (busy) begin
      rem      <= q_bit ? rem_diff[ACC_BITS-1:0] : rem_sh[ACC_BITS-1:0];
      bits     <= {bits[DIV_BITS-2:0], 1'b0};
      quotient <= {quotient[DIV_BITS-2:0], q_bit};
    end
  end

endmodule

FILE: hw/rtl/dmi_datapath.sv
`timescale 1ns / 1ps
module dmi_datapath import dmi_pkg::*; #(
  parameter int PRICE_BITS    = PRICE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_opcode,
  input  logic [IN_PRICE_BITS-1:0] in_high,
  input  logic [IN_PRICE_BITS-1:0] in_low,
  input  logic [IN_PRICE_BITS-1:0] in_close,
  input  logic [PERIOD_BITS-1:0]   period,
  input  dmi_cmd_t                 cmd,
  output dmi_stat_t                stat,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PCT_OUT_BITS-1:0]  out_plus_di,
  output logic [PCT_OUT_BITS-1:0]  out_neg_di,
  output logic [PCT_OUT_BITS-1:0]  out_dx,
  output logic [PCT_OUT_BITS-1:0]  out_adx,
  output logic                     out_di_valid,
  output logic                     out_adx_valid
);

  localparam int PW    = (PRICE_BITS < IN_PRICE_BITS) ? PRICE_BITS : IN_PRICE_BITS;
  localparam int PCTW  = FRACTION_BITS + PCT_INT_BITS;
  localparam int PRODW = PCTW + PERIOD_BITS + 1;
  localparam int MW    = ACC_BITS + PCT_INT_BITS;
  localparam logic [PCTW-1:0] FULL = PCTW'(PCT_SCALE << FRACTION_BITS);

  logic                   op_q;
  logic [PW-1:0]          hi, lo, cl;
  logic                   have_prev;
  logic [PW-1:0]          last_high, last_low, last_close;
  logic [PERIOD_BITS-1:0] seed_cnt, dx_cnt;
  logic [ACC_BITS-1:0]    tr_acc, pm_acc, mm_acc;
  logic [PW-1:0]          tr_x, pm_x, mm_x;
  logic                   dir_ready, avg_ready;
  logic [DXSUM_BITS-1:0]  dx_total;
  logic [PCTW-1:0]        avg, pdi, mdi, dx;
  logic [PRODW-1:0]       prod;
  ovr_t                   ovr;

  logic [PERIOD_BITS-1:0] p_eff, seed_inc, dx_inc;
  logic [PW-1:0]          tr_c, pdm_c, mdm_c, t1, t2;
  logic signed [PW:0]     up, dn;
  logic [ACC_BITS:0]      tr_sum, pm_sum, mm_sum;
  logic [ACC_BITS-1:0]    pct_n, pct_d, sm_acc, sm_new;
  logic [PW-1:0]          sm_x;
  logic [ACC_BITS:0]      sm_sum;
  logic [MW-1:0]          m;
  logic [PCTW-1:0]        pct_res;
  logic [DXSUM_BITS:0]    dx_sum;
  logic [ACC_BITS-1:0]    div_rem0, div_dvs;
  logic [DIV_BITS-1:0]    div_bits0, quo;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic                   div_busy, div_done;

  // bar front end: range and directional movement
  always_comb begin
    p_eff    = (period == '0) ? PERIOD_BITS'(1) : period;
    seed_inc = (seed_cnt == '1) ? seed_cnt : seed_cnt + 1'b1;
    dx_inc   = (dx_cnt == '1) ? dx_cnt : dx_cnt + 1'b1;
    up       = $signed({1'b0, hi}) - $signed({1'b0, last_high});
    dn       = $signed({1'b0, last_low}) - $signed({1'b0, lo});
    t1       = (hi >= last_close) ? hi - last_close : last_close - hi;
    t2       = (lo >= last_close) ? lo - last_close : last_close - lo;
    tr_c     = (hi >= lo) ? hi - lo : lo - hi;
    pdm_c    = '0;
    mdm_c    = '0;
    if (have_prev) begin
      if (up > dn && !up[PW] && up != '0) pdm_c = up[PW-1:0];
      if (dn > up && !dn[PW] && dn != '0) mdm_c = dn[PW-1:0];
      if (t1 > tr_c) tr_c = t1;
      if (t2 > tr_c) tr_c = t2;
    end
    tr_sum = {1'b0, tr_acc} + (ACC_BITS + 1)'(tr_c);
    pm_sum = {1'b0, pm_acc} + (ACC_BITS + 1)'(pdm_c);
    mm_sum = {1'b0, mm_acc} + (ACC_BITS + 1)'(mdm_c);
  end

  // divider operands and write-back
  always_comb begin
    case (cmd.div_sel)
      DIV_MDI: begin
        pct_n = mm_acc;
        pct_d = tr_acc;
      end
      DIV_DX: begin
        pct_n = ACC_BITS'((pdi >= mdi) ? pdi - mdi : mdi - pdi);
        pct_d = ACC_BITS'({1'b0, pdi} + {1'b0, mdi});
      end
      default: begin
        pct_n = pm_acc;
        pct_d = tr_acc;
      end
    endcase
    case (cmd.div_sel)
      DIV_PM: begin
        sm_acc = pm_acc;
        sm_x   = pm_x;
      end
      DIV_MM: begin
        sm_acc = mm_acc;
        sm_x   = mm_x;
      end
      default: begin
        sm_acc = tr_acc;
        sm_x   = tr_x;
      end
    endcase
    m = MW'(pct_n) * MW'(PCT_SCALE);
    case (cmd.div_sel)
      DIV_TR, DIV_PM, DIV_MM: begin
        div_rem0  = '0;
        div_bits0 = {sm_acc, {(DIV_BITS - ACC_BITS){1'b0}}};
        div_dvs   = ACC_BITS'(p_eff);
        div_cnt   = DIV_CNT_BITS'(ACC_BITS);
      end
      DIV_PDI, DIV_MDI, DIV_DX: begin
        div_rem0  = m[MW-1:PCT_INT_BITS];
        div_bits0 = {m[PCT_INT_BITS-1:0], {(DIV_BITS - PCT_INT_BITS){1'b0}}};
        div_dvs   = pct_d;
        div_cnt   = DIV_CNT_BITS'(PCTW);
      end
      DIV_AVG: begin
        div_rem0  = '0;
        div_bits0 = avg_ready ? DIV_BITS'(prod) : DIV_BITS'(dx_total);
        div_dvs   = ACC_BITS'(p_eff);
        div_cnt   = DIV_CNT_BITS'(DIV_BITS);
      end
      default: begin
        div_rem0  = '0;
        div_bits0 = '0;
        div_dvs   = '0;
        div_cnt   = '0;
      end
    endcase
    sm_sum = {1'b0, sm_acc - quo[ACC_BITS-1:0]} + (ACC_BITS + 1)'(sm_x);
    sm_new = sm_sum[ACC_BITS] ? '1 : sm_sum[ACC_BITS-1:0];
    case (ovr)
      OVR_ZERO: pct_res = '0;
      OVR_FULL: pct_res = FULL;
      default:  pct_res = PCTW'(quo);
    endcase
    dx_sum = {1'b0, dx_total} + (DXSUM_BITS + 1)'(dx);
  end

  dmi_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .rem_init  (div_rem0),
    .bits_init (div_bits0),
    .divisor   (div_dvs),
    .count     (div_cnt),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (quo)
  );

  always_comb begin
    stat.op_clear     = (op_q == OP_CLEAR);
    stat.seed_open    = !dir_ready && (seed_inc < p_eff);
    stat.dir_ready    = dir_ready;
    stat.adx_need_div = avg_ready || (dx_inc >= p_eff);
    stat.div_done     = div_done;
    stat.div_busy     = div_busy;
    stat.out_free     = !out_valid || out_ready;
  end

  // captured request and per-bar working values
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= in_opcode;
      hi   <= in_high[PW-1:0];
      lo   <= in_low[PW-1:0];
      cl   <= in_close[PW-1:0];
    end
    if (cmd.prep) begin
      tr_x <= tr_c;
      pm_x <= pdm_c;
      mm_x <= mdm_c;
    end
    if (cmd.div_start) begin
      if (pct_d == '0) ovr <= OVR_ZERO;
      else if (pct_n >= pct_d) ovr <= OVR_FULL;
      else ovr <= OVR_NONE;
    end
    if (cmd.adx_prep) begin
      prod <= PRODW'(avg) * PRODW'(p_eff - 1'b1) + PRODW'(dx);
    end
  end

  // indicator state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      have_prev  <= 1'b0;
      last_high  <= '0;
      last_low   <= '0;
      last_close <= '0;
      seed_cnt   <= '0;
      tr_acc     <= '0;
      pm_acc     <= '0;
      mm_acc     <= '0;
      dir_ready  <= 1'b0;
      dx_cnt     <= '0;
      dx_total   <= '0;
      avg_ready  <= 1'b0;
      avg        <= '0;
      pdi        <= '0;
      mdi        <= '0;
      dx         <= '0;
    end else begin
      if (cmd.prep) begin
        last_high  <= hi;
        last_low   <= lo;
        last_close <= cl;
        have_prev  <= 1'b1;
        if (!dir_ready) begin
          tr_acc   <= tr_sum[ACC_BITS] ? '1 : tr_sum[ACC_BITS-1:0];
          pm_acc   <= pm_sum[ACC_BITS] ? '1 : pm_sum[ACC_BITS-1:0];
          mm_acc   <= mm_sum[ACC_BITS] ? '1 : mm_sum[ACC_BITS-1:0];
          seed_cnt <= seed_inc;
          if (seed_inc >= p_eff) dir_ready <= 1'b1;
        end
      end
      if (div_done) begin
        case (cmd.div_sel)
          DIV_TR:  tr_acc <= sm_new;
          DIV_PM:  pm_acc <= sm_new;
          DIV_MM:  mm_acc <= sm_new;
          DIV_PDI: pdi <= pct_res;
          DIV_MDI: mdi <= pct_res;
          DIV_DX:  dx <= pct_res;
          DIV_AVG: begin
            avg       <= PCTW'(quo);
            avg_ready <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.adx_prep && !avg_ready) begin
        dx_total <= dx_sum[DXSUM_BITS] ? '1 : dx_sum[DXSUM_BITS-1:0];
        dx_cnt   <= dx_inc;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      out_plus_di   <= cmd.blank ? '0 : PCT_OUT_BITS'(pdi);
      out_neg_di    <= cmd.blank ? '0 : PCT_OUT_BITS'(mdi);
      out_dx        <= cmd.blank ? '0 : PCT_OUT_BITS'(dx);
      out_adx       <= (cmd.blank || !avg_ready) ? '0 : PCT_OUT_BITS'(avg);
      out_di_valid  <= !cmd.blank;
      out_adx_valid <= !cmd.blank && avg_ready;
    end
  end

endmodule

FILE: hw/rtl/dmi_ctrl.sv
`timescale 1ns / 1ps
module dmi_ctrl import dmi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      bar_valid,
  output logic      bar_ready,
  input  dmi_stat_t stat,
  output dmi_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_PREP    = 6'b000010,
    ST_DIV_GO  = 6'b000100,
    ST_DIV_RUN = 6'b001000,
    ST_ADX     = 6'b010000,
    ST_DELIVER = 6'b100000
  } state_t;

  state_t   state, state_next;
  div_sel_t sel, sel_next;
  logic     blank, blank_next;

  always_comb begin
    state_next  = state;
    sel_next    = sel;
    blank_next  = blank;
    cmd         = '0;
    cmd.div_sel = sel;
    cmd.blank   = blank;
    bar_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        bar_ready = 1'b1;
        if (bar_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_PREP;
        end
      end
      ST_PREP: begin
        if (stat.op_clear) begin
          cmd.clear  = 1'b1;
          blank_next = 1'b1;
          state_next = ST_DELIVER;
        end else begin
          cmd.prep = 1'b1;
          if (stat.seed_open) begin
            blank_next = 1'b1;
            state_next = ST_DELIVER;
          end else begin
            blank_next = 1'b0;
            sel_next   = stat.dir_ready ? DIV_TR : DIV_PDI;
            state_next = ST_DIV_GO;
          end
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (stat.div_done) begin
          state_next = ST_DIV_GO;
          case (sel)
            DIV_TR:  sel_next = DIV_PM;
            DIV_PM:  sel_next = DIV_MM;
            DIV_MM:  sel_next = DIV_PDI;
            DIV_PDI: sel_next = DIV_MDI;
            DIV_MDI: sel_next = DIV_DX;
            DIV_DX:  state_next = ST_ADX;
            default: state_next = ST_DELIVER;
          endcase
        end
      end
      ST_ADX: begin
        cmd.adx_prep = 1'b1;
        if (stat.adx_need_div) begin
          sel_next   = DIV_AVG;
          state_next = ST_DIV_GO;
        end else begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (stat.out_free) begin
          cmd.deliver = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= DIV_TR;
      blank <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      blank <= blank_next;
    end
  end

endmodule
